// ----- rtl/core/stt_pkg.sv -----
// Shared types and constants for the source token scanner.
// Used by stt_scan_core, stt_out_queue and source_token_scanner; no dependencies.

package stt_pkg;

    localparam int MAX_TOKEN_LEN_DEFAULT = 32;
    localparam int POS_WIDTH_DEFAULT     = 32;
    localparam int QUEUE_DEPTH           = 4;

    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd1;
    localparam logic [4:0] KIND_FUNC   = 5'd2;
    localparam logic [4:0] KIND_RETURN = 5'd3;
    localparam logic [4:0] KIND_INT    = 5'd4;
    localparam logic [4:0] KIND_LPAREN = 5'd5;
    localparam logic [4:0] KIND_RPAREN = 5'd6;
    localparam logic [4:0] KIND_COLON  = 5'd7;
    localparam logic [4:0] KIND_COMMA  = 5'd8;
    localparam logic [4:0] KIND_LBRACE = 5'd9;
    localparam logic [4:0] KIND_RBRACE = 5'd10;
    localparam logic [4:0] KIND_PLUS   = 5'd11;
    localparam logic [4:0] KIND_MINUS  = 5'd12;
    localparam logic [4:0] KIND_STAR   = 5'd13;
    localparam logic [4:0] KIND_SLASH  = 5'd14;
    localparam logic [4:0] KIND_ARROW  = 5'd15;
    localparam logic [4:0] KIND_EQEQ   = 5'd16;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] start_pos;
        logic [5:0]  token_length;
        logic [30:0] int_value;
        logic        leading_space;
        logic        last_result;
    } token_result_t;

    // Results produced by one accepted request, packed from the first slot.
    typedef struct packed {
        logic [1:0]    count;
        token_result_t first;
        token_result_t second;
    } result_push_t;

endpackage

// ----- rtl/core/source_token_scanner.sv -----
// Source token scanner: takes one source byte per request and returns tokens
// (kind, start offset, length, integer value, leading-space flag). Each byte is
// held for one request so that the next byte serves as lookahead; an
// end-of-input request flushes the held byte and adds an end-of-file token,
// then the scanner restarts at offset zero. One request is accepted per clock
// cycle while the four-entry result queue has two free slots; s_ready drops only
// when results back up at m_ready. The results of a request are written into
// the result queue, which is registered. Depends on stt_pkg, stt_scan_core and
// stt_out_queue.

module source_token_scanner #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEFAULT,
    parameter int POS_WIDTH     = stt_pkg::POS_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_token_kind,
    output logic [31:0] m_start_pos,
    output logic [5:0]  m_token_length,
    output logic [30:0] m_int_value,
    output logic        m_leading_space,
    output logic        m_last_result
);

    stt_pkg::result_push_t  push;
    stt_pkg::token_result_t head;
    logic                   accept;
    logic                   room;

    assign s_ready = room;
    assign accept  = s_valid && room;

    stt_scan_core #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POS_WIDTH     (POS_WIDTH)
    ) u_scan_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .char_code    (s_char_code),
        .end_of_input (s_end_of_input),
        .push         (push)
    );

    stt_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop_ready (m_ready),
        .room      (room),
        .out_valid (m_valid),
        .out_data  (head)
    );

    assign m_token_kind    = head.token_kind;
    assign m_start_pos     = head.start_pos;
    assign m_token_length  = head.token_length;
    assign m_int_value     = head.int_value;
    assign m_leading_space = head.leading_space;
    assign m_last_result   = head.last_result;

endmodule

// ----- rtl/core/stt_scan_core.sv -----
// Scanner state and per-character token logic for the source token scanner.
// Depends on stt_pkg for the result types and token kind codes.

module stt_scan_core #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEFAULT,
    parameter int POS_WIDTH     = stt_pkg::POS_WIDTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           char_code,
    input  logic                 end_of_input,
    output stt_pkg::result_push_t push
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [34:0] INT_SAT = 35'd2147483647;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    function automatic logic [7:0] func_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h75;
            3'd2:    ch = 8'h6E;
            3'd3:    ch = 8'h63;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] return_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h75;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    logic [7:0]           held_char_reg, held_char_next;
    logic                 held_valid_reg, held_valid_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [POS_WIDTH-1:0] start_reg, start_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [30:0]          acc_reg, acc_next;
    logic                 all_digits_reg, all_digits_next;
    logic                 func_match_reg, func_match_next;
    logic                 return_match_reg, return_match_next;
    logic                 space_reg, space_next;
    logic                 comment_reg, comment_next;
    logic [7:0]           first_reg, first_next;

    // Scan results for the held character.
    logic [LEN_W-1:0]     sc_len;
    logic [POS_WIDTH-1:0] sc_start;
    logic [POS_WIDTH-1:0] sc_pos;
    logic [30:0]          sc_acc;
    logic                 sc_all_digits;
    logic                 sc_func;
    logic                 sc_return;
    logic                 sc_space;
    logic                 sc_comment;
    logic [7:0]           sc_first;
    logic                 sc_emit;
    stt_pkg::token_result_t sc_res;
    stt_pkg::token_result_t eof_res;

    logic [7:0]           c;
    logic [7:0]           la_char;
    logic                 la_end;
    logic                 ends_word;
    logic                 two;
    logic                 found;
    logic [4:0]           kind;
    logic [LEN_W-1:0]     len_inc;
    logic [34:0]          prod;

    assign c       = held_char_reg;
    assign la_end  = end_of_input;
    assign la_char = char_code;
    assign ends_word = la_end || is_space(la_char) ||
                       (la_char inside {CH_COMMA, CH_DOT, CH_LPAREN, CH_RPAREN,
                                        CH_LBRACE, CH_RBRACE, CH_COLON, CH_MINUS});

    always_comb begin
        sc_len        = len_reg;
        sc_start      = start_reg;
        sc_pos        = pos_reg;
        sc_acc        = acc_reg;
        sc_all_digits = all_digits_reg;
        sc_func       = func_match_reg;
        sc_return     = return_match_reg;
        sc_space      = space_reg;
        sc_comment    = comment_reg;
        sc_first      = first_reg;
        sc_emit       = 1'b0;
        sc_res        = '0;
        two           = 1'b0;
        found         = 1'b0;
        kind          = stt_pkg::KIND_EOF;
        len_inc       = len_reg;
        prod          = '0;
        if (held_valid_reg) begin
            sc_pos = pos_reg + POS_WIDTH'(1);
            if (comment_reg) begin
                if (c == CH_NEWLINE) begin
                    sc_comment = 1'b0;
                    sc_space   = 1'b0;
                end
            end else if (len_reg == '0 && is_space(c)) begin
                sc_space = 1'b1;
            end else begin
                if (len_reg == '0) begin
                    sc_start      = pos_reg;
                    sc_first      = c;
                    sc_all_digits = 1'b1;
                    sc_func       = 1'b1;
                    sc_return     = 1'b1;
                    sc_acc        = '0;
                end
                sc_func   = sc_func && len_reg < LEN_W'(4) && c == func_char(len_reg[2:0]);
                sc_return = sc_return && len_reg < LEN_W'(6) &&
                            c == return_char(len_reg[2:0]);
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    prod = ({4'b0, sc_acc} << 3) + ({4'b0, sc_acc} << 1) +
                           35'(c - CH_ZERO);
                    sc_acc = (prod > INT_SAT) ? INT_SAT[30:0] : prod[30:0];
                end else begin
                    sc_all_digits = 1'b0;
                end
                len_inc = (len_reg < LEN_MAX) ? len_reg + LEN_W'(1) : len_reg;
                sc_len  = len_inc;
                two     = len_inc == LEN_W'(2);
                if (two && sc_first == CH_SLASH && c == CH_SLASH) begin
                    sc_comment = 1'b1;
                    sc_len     = '0;
                end else begin
                    case (c)
                        CH_LPAREN: begin found = 1'b1; kind = stt_pkg::KIND_LPAREN; end
                        CH_RPAREN: begin found = 1'b1; kind = stt_pkg::KIND_RPAREN; end
                        CH_COLON:  begin found = 1'b1; kind = stt_pkg::KIND_COLON;  end
                        CH_COMMA:  begin found = 1'b1; kind = stt_pkg::KIND_COMMA;  end
                        CH_LBRACE: begin found = 1'b1; kind = stt_pkg::KIND_LBRACE; end
                        CH_RBRACE: begin found = 1'b1; kind = stt_pkg::KIND_RBRACE; end
                        CH_PLUS:   begin found = 1'b1; kind = stt_pkg::KIND_PLUS;   end
                        CH_STAR:   begin found = 1'b1; kind = stt_pkg::KIND_STAR;   end
                        CH_MINUS: begin
                            if (la_end || la_char != CH_GT) begin
                                found = 1'b1;
                                kind  = stt_pkg::KIND_MINUS;
                            end
                        end
                        CH_SLASH: begin
                            if (la_end || la_char != CH_SLASH) begin
                                found = 1'b1;
                                kind  = stt_pkg::KIND_SLASH;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!found && two && sc_first == CH_MINUS && c == CH_GT) begin
                        found = 1'b1;
                        kind  = stt_pkg::KIND_ARROW;
                    end
                    if (!found && two && sc_first == CH_EQUALS && c == CH_EQUALS) begin
                        found = 1'b1;
                        kind  = stt_pkg::KIND_EQEQ;
                    end
                    if (!found && ends_word) begin
                        found = 1'b1;
                        if (sc_func && len_inc == LEN_W'(4)) begin
                            kind = stt_pkg::KIND_FUNC;
                        end else if (sc_return && len_inc == LEN_W'(6)) begin
                            kind = stt_pkg::KIND_RETURN;
                        end else if (sc_all_digits) begin
                            kind = stt_pkg::KIND_INT;
                        end else begin
                            kind = stt_pkg::KIND_IDENT;
                        end
                    end
                    if (found) begin
                        sc_emit             = 1'b1;
                        sc_res.token_kind   = kind;
                        sc_res.start_pos    = 32'(sc_start);
                        sc_res.token_length = 6'(len_inc);
                        if (kind == stt_pkg::KIND_INT) begin
                            sc_res.int_value     = sc_acc;
                            sc_res.leading_space = sc_space;
                        end
                        sc_len   = '0;
                        sc_space = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        eof_res             = '0;
        eof_res.token_kind  = stt_pkg::KIND_EOF;
        eof_res.start_pos   = 32'(sc_pos);
        eof_res.last_result = 1'b1;
    end

    always_comb begin
        held_char_next    = held_char_reg;
        held_valid_next   = held_valid_reg;
        len_next          = len_reg;
        start_next        = start_reg;
        pos_next          = pos_reg;
        acc_next          = acc_reg;
        all_digits_next   = all_digits_reg;
        func_match_next   = func_match_reg;
        return_match_next = return_match_reg;
        space_next        = space_reg;
        comment_next      = comment_reg;
        first_next        = first_reg;
        push              = '0;
        if (accept) begin
            if (end_of_input) begin
                // The source ends here: flush the held character, then start afresh.
                held_char_next    = '0;
                held_valid_next   = 1'b0;
                len_next          = '0;
                start_next        = '0;
                pos_next          = '0;
                acc_next          = '0;
                all_digits_next   = 1'b1;
                func_match_next   = 1'b1;
                return_match_next = 1'b1;
                space_next        = 1'b0;
                comment_next      = 1'b0;
                first_next        = '0;
                if (sc_emit) begin
                    push.count  = 2'd2;
                    push.first  = sc_res;
                    push.second = eof_res;
                end else begin
                    push.count = 2'd1;
                    push.first = eof_res;
                end
            end else begin
                held_char_next    = char_code;
                held_valid_next   = 1'b1;
                len_next          = sc_len;
                start_next        = sc_start;
                pos_next          = sc_pos;
                acc_next          = sc_acc;
                all_digits_next   = sc_all_digits;
                func_match_next   = sc_func;
                return_match_next = sc_return;
                space_next        = sc_space;
                comment_next      = sc_comment;
                first_next        = sc_first;
                if (sc_emit) begin
                    push.count             = 2'd1;
                    push.first             = sc_res;
                    push.first.last_result = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_char_reg    <= '0;
            held_valid_reg   <= 1'b0;
            len_reg          <= '0;
            start_reg        <= '0;
            pos_reg          <= '0;
            acc_reg          <= '0;
            all_digits_reg   <= 1'b1;
            func_match_reg   <= 1'b1;
            return_match_reg <= 1'b1;
            space_reg        <= 1'b0;
            comment_reg      <= 1'b0;
            first_reg        <= '0;
        end else begin
            held_char_reg    <= held_char_next;
            held_valid_reg   <= held_valid_next;
            len_reg          <= len_next;
            start_reg        <= start_next;
            pos_reg          <= pos_next;
            acc_reg          <= acc_next;
            all_digits_reg   <= all_digits_next;
            func_match_reg   <= func_match_next;
            return_match_reg <= return_match_next;
            space_reg        <= space_next;
            comment_reg      <= comment_next;
            first_reg        <= first_next;
        end
    end

    a_end_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_input |=> !held_valid_reg && pos_reg == '0 && len_reg == '0)
        else $error("end of input did not return the scanner to its initial state");

    a_eof_follows_token: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> push.second.token_kind == stt_pkg::KIND_EOF &&
                               push.second.last_result && !push.first.last_result)
        else $error("two results from one request without a closing eof token");

endmodule

// ----- rtl/core/stt_out_queue.sv -----
// Four-entry result queue taking up to two results per cycle and giving one while pop_ready is high.
// Depends on stt_pkg for the result types and the queue depth.

module stt_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  stt_pkg::result_push_t  push,
    input  logic                   pop_ready,
    output logic                   room,
    output logic                   out_valid,
    output stt_pkg::token_result_t out_data
);

    localparam int DEPTH = stt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stt_pkg::token_result_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign pop       = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue holds more entries than its depth");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> room)
        else $error("results pushed while the queue lacked room for two");

    a_pop_alone_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("result queue occupancy did not fall after a pop");

endmodule

// ----- dv/stt_token_checker.sv -----
// Token checker for the source token scanner: watches the request and result channels,
// predicts the tokens from the accepted bytes and compares every result field.
// Depends on stt_pkg for the token kinds and the result layout.

module stt_token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_input,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [4:0]  m_token_kind,
    input  logic [31:0] m_start_pos,
    input  logic [5:0]  m_token_length,
    input  logic [30:0] m_int_value,
    input  logic        m_leading_space,
    input  logic        m_last_result,
    output int          failures,
    output int          awaited
);

    localparam logic [5:0]  MAX_LEN   = 6'(stt_pkg::MAX_TOKEN_LEN_DEFAULT);
    localparam logic [8:0]  LOOK_END  = 9'h100;
    localparam logic [30:0] INT_LIMIT = 31'h7FFF_FFFF;
    localparam logic [31:0] FUNC_TEXT   = "func";
    localparam logic [47:0] RETURN_TEXT = "return";

    logic [7:0]  held_byte;
    logic        held_ok;
    logic [5:0]  word_len;
    logic [31:0] word_start;
    logic [31:0] char_pos;
    logic [30:0] digit_value;
    logic        only_digits;
    logic        may_be_func;
    logic        may_be_return;
    logic        gap_seen;
    logic        skipping_comment;
    logic [7:0]  lead_byte;

    stt_pkg::token_result_t expected_tokens[$];
    stt_pkg::token_result_t step_tokens[2];
    int                     step_count;

    initial begin
        failures = 0;
        awaited  = 0;
    end

    function automatic logic is_space(input logic [8:0] x);
        return x == 9'h20 || (x >= 9'h09 && x <= 9'h0D);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: token mismatch: %s", $time, what);
        failures++;
    endtask

    task automatic clear_scanner();
        held_byte        = 8'h00;
        held_ok          = 1'b0;
        word_len         = 6'd0;
        word_start       = 32'd0;
        char_pos         = 32'd0;
        digit_value      = 31'd0;
        only_digits      = 1'b1;
        may_be_func      = 1'b1;
        may_be_return    = 1'b1;
        gap_seen         = 1'b0;
        skipping_comment = 1'b0;
        lead_byte        = 8'h00;
    endtask

    task automatic emit_token(input logic [4:0] kind, input logic [31:0] start,
                              input logic [5:0] len, input logic [30:0] value,
                              input logic lead);
        stt_pkg::token_result_t t;
        t.token_kind    = kind;
        t.start_pos     = start;
        t.token_length  = len;
        t.int_value     = value;
        t.leading_space = lead;
        t.last_result   = 1'b0;
        step_tokens[step_count] = t;
        step_count++;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic [8:0] look);
        logic [31:0] here;
        logic [4:0]  kind;
        logic        found;
        logic        pair;
        logic        ends;
        logic [63:0] grown;
        int          idx;
        here     = char_pos;
        char_pos = char_pos + 32'd1;
        kind     = stt_pkg::KIND_EOF;
        found    = 1'b0;
        if (skipping_comment) begin
            if (c == 8'h0A) begin
                skipping_comment = 1'b0;
                gap_seen         = 1'b0;
            end
            return;
        end
        if (word_len == 6'd0) begin
            if (is_space({1'b0, c})) begin
                gap_seen = 1'b1;
                return;
            end
            word_start    = here;
            lead_byte     = c;
            only_digits   = 1'b1;
            may_be_func   = 1'b1;
            may_be_return = 1'b1;
            digit_value   = 31'd0;
        end
        idx = int'(word_len);
        may_be_func   = may_be_func && idx < 4 && c == FUNC_TEXT[31 - 8 * idx -: 8];
        may_be_return = may_be_return && idx < 6 && c == RETURN_TEXT[47 - 8 * idx -: 8];
        if (c >= "0" && c <= "9") begin
            grown       = digit_value * 64'd10 + (c - "0");
            digit_value = (grown > INT_LIMIT) ? INT_LIMIT : grown[30:0];
        end else begin
            only_digits = 1'b0;
        end
        if (word_len < MAX_LEN) begin
            word_len = word_len + 6'd1;
        end
        pair = (word_len == 6'd2);
        if (pair && lead_byte == "/" && c == "/") begin
            skipping_comment = 1'b1;
            word_len         = 6'd0;
            return;
        end
        case (c)
            "(": begin kind = stt_pkg::KIND_LPAREN; found = 1'b1; end
            ")": begin kind = stt_pkg::KIND_RPAREN; found = 1'b1; end
            ":": begin kind = stt_pkg::KIND_COLON;  found = 1'b1; end
            ",": begin kind = stt_pkg::KIND_COMMA;  found = 1'b1; end
            "{": begin kind = stt_pkg::KIND_LBRACE; found = 1'b1; end
            "}": begin kind = stt_pkg::KIND_RBRACE; found = 1'b1; end
            "+": begin kind = stt_pkg::KIND_PLUS;   found = 1'b1; end
            "*": begin kind = stt_pkg::KIND_STAR;   found = 1'b1; end
            "-": begin
                if (look != ">") begin
                    kind  = stt_pkg::KIND_MINUS;
                    found = 1'b1;
                end
            end
            "/": begin
                if (look != "/") begin
                    kind  = stt_pkg::KIND_SLASH;
                    found = 1'b1;
                end
            end
            default: ;
        endcase
        if (!found && pair && lead_byte == "-" && c == ">") begin
            kind  = stt_pkg::KIND_ARROW;
            found = 1'b1;
        end
        if (!found && pair && lead_byte == "=" && c == "=") begin
            kind  = stt_pkg::KIND_EQEQ;
            found = 1'b1;
        end
        ends = look == LOOK_END || is_space(look) || look == "," || look == "." ||
               look == "(" || look == ")" || look == "{" || look == "}" ||
               look == ":" || look == "-";
        if (!found && ends) begin
            found = 1'b1;
            if (may_be_func && word_len == 6'd4) begin
                kind = stt_pkg::KIND_FUNC;
            end else if (may_be_return && word_len == 6'd6) begin
                kind = stt_pkg::KIND_RETURN;
            end else if (only_digits) begin
                kind = stt_pkg::KIND_INT;
            end else begin
                kind = stt_pkg::KIND_IDENT;
            end
        end
        if (found) begin
            if (kind == stt_pkg::KIND_INT) begin
                emit_token(kind, word_start, word_len, digit_value, gap_seen);
            end else begin
                emit_token(kind, word_start, word_len, 31'd0, 1'b0);
            end
            word_len = 6'd0;
            gap_seen = 1'b0;
        end
    endtask

    task automatic tokenise_step(input logic [7:0] c, input logic eoi);
        step_count = 0;
        if (eoi) begin
            if (held_ok) begin
                scan_byte(held_byte, LOOK_END);
            end
            emit_token(stt_pkg::KIND_EOF, char_pos, 6'd0, 31'd0, 1'b0);
            clear_scanner();
        end else begin
            if (held_ok) begin
                scan_byte(held_byte, {1'b0, c});
            end
            held_byte = c;
            held_ok   = 1'b1;
        end
        if (step_count > 0) begin
            step_tokens[step_count - 1].last_result = 1'b1;
        end
        for (int i = 0; i < step_count; i++) begin
            expected_tokens.push_back(step_tokens[i]);
        end
    endtask

    task automatic check_token();
        stt_pkg::token_result_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("kind %0d at %0d arrived with no token awaited",
                                      m_token_kind, m_start_pos));
            return;
        end
        want = expected_tokens.pop_front();
        if (m_token_kind !== want.token_kind) begin
            report_mismatch($sformatf("token_kind expected %0d, got %0d",
                                      want.token_kind, m_token_kind));
        end
        if (m_start_pos !== want.start_pos) begin
            report_mismatch($sformatf("start_pos expected %0d, got %0d",
                                      want.start_pos, m_start_pos));
        end
        if (m_token_length !== want.token_length) begin
            report_mismatch($sformatf("token_length expected %0d, got %0d",
                                      want.token_length, m_token_length));
        end
        if (m_int_value !== want.int_value) begin
            report_mismatch($sformatf("int_value expected %0d, got %0d",
                                      want.int_value, m_int_value));
        end
        if (m_leading_space !== want.leading_space) begin
            report_mismatch($sformatf("leading_space expected %0b, got %0b",
                                      want.leading_space, m_leading_space));
        end
        if (m_last_result !== want.last_result) begin
            report_mismatch($sformatf("last_result expected %0b, got %0b",
                                      want.last_result, m_last_result));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scanner();
            expected_tokens.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_token();
            end
            if (s_valid && s_ready) begin
                tokenise_step(s_char_code, s_end_of_input);
            end
        end
        awaited = expected_tokens.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the source token scanner: drives source bytes and
// end-of-input requests, stalls the result side and gives the verdict.
// Depends on stt_pkg, source_token_scanner and stt_token_checker.

module tb;

    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'h00;
    logic        s_end_of_input = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_token_kind;
    logic [31:0] m_start_pos;
    logic [5:0]  m_token_length;
    logic [30:0] m_int_value;
    logic        m_leading_space;
    logic        m_last_result;

    int failures;
    int awaited;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int idle_plan[4] = '{0, 50, 0, 36};
    int stall_plan[4] = '{0, 0, 50, 36};

    source_token_scanner DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_start_pos     (m_start_pos),
        .m_token_length  (m_token_length),
        .m_int_value     (m_int_value),
        .m_leading_space (m_leading_space),
        .m_last_result   (m_last_result)
    );

    stt_token_checker token_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_start_pos     (m_start_pos),
        .m_token_length  (m_token_length),
        .m_int_value     (m_int_value),
        .m_leading_space (m_leading_space),
        .m_last_result   (m_last_result),
        .failures        (failures),
        .awaited         (awaited)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_char(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < idle_pct) begin
            s_valid     <= 1'b0;
            s_char_code <= 8'($urandom_range(255));
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_code    <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_char(t[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] random_space();
        if ($urandom_range(1)) begin
            return " ";
        end
        return 8'(8'h09 + $urandom_range(4));
    endfunction

    task automatic send_random_token();
        int    n;
        string punct;
        punct = "(){}:,+-*/.";
        case ($urandom_range(11))
            0, 1: begin
                n = ($urandom_range(11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
                repeat (n) send_char(8'("a" + $urandom_range(25)), 1'b0);
            end
            2: begin
                if ($urandom_range(1)) begin
                    send_text("func");
                end else begin
                    send_text("return");
                end
            end
            3, 4: begin
                n = ($urandom_range(7) == 0) ? $urandom_range(10, 36) : $urandom_range(1, 5);
                repeat (n) send_char(8'("0" + $urandom_range(9)), 1'b0);
            end
            5, 6: send_char(punct[$urandom_range(punct.len() - 1)], 1'b0);
            7: begin
                case ($urandom_range(3))
                    0: send_text("->");
                    1: send_text("==");
                    2: send_char("=", 1'b0);
                    default: send_char(">", 1'b0);
                endcase
            end
            8: repeat ($urandom_range(1, 3)) send_char(random_space(), 1'b0);
            9: begin
                send_text("//");
                repeat ($urandom_range(4)) send_char(8'($urandom_range(255)), 1'b0);
                if ($urandom_range(3) != 0) begin
                    send_char(8'h0A, 1'b0);
                end
            end
            10: send_char(8'($urandom_range(255)), 1'b0);
            default: begin
                send_char(8'("a" + $urandom_range(25)), 1'b0);
                repeat ($urandom_range(1, 4)) send_char(8'("0" + $urandom_range(9)), 1'b0);
            end
        endcase
    endtask

    task automatic send_random_source();
        repeat ($urandom_range(12)) begin
            if ($urandom_range(1)) begin
                send_char(random_space(), 1'b0);
            end
            send_random_token();
        end
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_char(8'hFF, 1'b0);
        send_text(" ab+//");
        send_char(8'h00, 1'b1);
        send_text("func(");
        send_char(8'h00, 1'b0);
        send_text("->==):{},*");
        send_char(8'hFF, 1'b1);
        send_text("return//\n 3/");
        send_char(8'($urandom_range(255)), 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_plan[phase];
            stall_pct = stall_plan[phase];
            while (items_sent < (phase + 1) * ITEM_TARGET / 4) begin
                send_random_source();
            end
        end
        s_valid <= 1'b0;

        while (awaited != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("PASS source_token_scanner");
        end else begin
            $display("FAIL source_token_scanner");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL source_token_scanner");
        $finish;
    end

endmodule
